>>> rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared constants, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath of the frame
// ring allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

  // Ring and marker queue sizing.
  localparam int MARKER_DEPTH = 16;
  localparam int PTR_W        = $clog2(MARKER_DEPTH);
  localparam int FILL_W       = $clog2(MARKER_DEPTH + 1);
  localparam int CNT_W        = 17;
  localparam int FRAME_W      = 64;
  localparam int PLACE_W      = 2 * CNT_W;

  localparam logic [CNT_W-1:0] RING_MAX      = 17'd65536;
  localparam logic [CNT_W-1:0] BUF_SIZE_RST  = 17'd65536;

  // Operation codes.
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FINISH  = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic alloc;
    logic finish;
    logic nop;
    logic rel_start;
    logic rel_pop;
    logic rel_done;
  } fra_cmd_t;

  typedef struct packed {
    logic rel_hit;
  } fra_stat_t;

endpackage

`default_nettype wire

>>> rtl/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl
// Controller of the frame ring allocator. Decodes accepted items and steps
// a release through its marker pops, each pop going through S_LOAD and S_CHECK.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_ctrl
  import fra_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] func,
  input  fra_stat_t       stat,
  output fra_cmd_t        cmd,
  output logic            busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.alloc     = accept && (func == FUNC_ALLOC);
    cmd.finish    = accept && (func == FUNC_FINISH);
    cmd.rel_start = accept && (func == FUNC_RELEASE);
    cmd.nop       = accept && (func != FUNC_ALLOC) && (func != FUNC_FINISH)
                    && (func != FUNC_RELEASE);
    cmd.rel_pop   = (state == S_CHECK) && stat.rel_hit;
    cmd.rel_done  = (state == S_CHECK) && !stat.rel_hit;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.rel_start) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // After a pop the registered read of the marker memory must present the next entry, so S_LOAD comes first.
        state_next = stat.rel_hit ? S_LOAD : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fra_dp.sv
// ----------------------------------------------------------------------------
// fra_dp
// Datapath of the frame ring allocator: ring counters, allocation fit logic,
// the marker queue memory and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_dp
  import fra_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CNT_W-1:0]   cfg_wdata,
  input  wire logic [CNT_W-1:0]   alloc_size,
  input  wire logic [FRAME_W-1:0] frame_number,
  input  fra_cmd_t                cmd,
  output fra_stat_t               stat,
  output logic                    done,
  output logic [1:0]              status,
  output logic [CNT_W-1:0]        offset,
  output logic [CNT_W-1:0]        used_bytes,
  output logic [4:0]              released_count
);

  logic [CNT_W-1:0]   buffer_size;
  logic [CNT_W-1:0]   head;
  logic [CNT_W-1:0]   tail;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   frame_bytes;
  logic [PTR_W-1:0]   read_ptr;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  popped;
  logic [FRAME_W-1:0] bound;

  logic [PLACE_W-1:0] mark_place [MARKER_DEPTH];
  logic [FRAME_W-1:0] mark_frame [MARKER_DEPTH];
  logic [PLACE_W-1:0] rd_place;
  logic [FRAME_W-1:0] rd_frame;

  // Allocation fit.
  logic [CNT_W-1:0] cap;
  logic [CNT_W:0]   sum_tail;
  logic [CNT_W-1:0] waste;
  logic             grant;
  logic [CNT_W-1:0] grant_off;
  logic [CNT_W-1:0] tail_next;
  logic [CNT_W:0]   add_amt;
  logic [CNT_W+1:0] used_sum;
  logic [CNT_W+1:0] frame_sum;
  logic [CNT_W-1:0] used_next;
  logic [CNT_W-1:0] frame_next;

  // Marker push and pop.
  logic             full;
  logic [PTR_W-1:0] wr_slot;
  logic [CNT_W-1:0] msize;
  logic [CNT_W-1:0] used_pop;

  always_comb begin
    cap       = (buffer_size > RING_MAX) ? RING_MAX : buffer_size;
    sum_tail  = {1'b0, tail} + {1'b0, alloc_size};
    waste     = (tail > cap) ? '0 : cap - tail;
    grant     = 1'b0;
    grant_off = '0;
    tail_next = tail;
    add_amt   = '0;
    if (used >= cap) begin
      grant = 1'b0;
    end else if (tail >= head) begin
      if (sum_tail <= {1'b0, cap}) begin
        grant     = 1'b1;
        grant_off = tail;
        tail_next = sum_tail[CNT_W-1:0];
        add_amt   = {1'b0, alloc_size};
      end else if (alloc_size <= head) begin
        // Wrap to the ring start; the unused end space is charged as used.
        grant     = 1'b1;
        grant_off = '0;
        tail_next = alloc_size;
        add_amt   = {1'b0, waste} + {1'b0, alloc_size};
      end
    end else if (sum_tail <= {1'b0, head}) begin
      grant     = 1'b1;
      grant_off = tail;
      tail_next = sum_tail[CNT_W-1:0];
      add_amt   = {1'b0, alloc_size};
    end
    used_sum   = {2'b00, used} + {1'b0, add_amt};
    frame_sum  = {2'b00, frame_bytes} + {1'b0, add_amt};
    used_next  = (used_sum > {2'b00, RING_MAX}) ? RING_MAX : used_sum[CNT_W-1:0];
    frame_next = (frame_sum > {2'b00, RING_MAX}) ? RING_MAX : frame_sum[CNT_W-1:0];
  end

  assign full     = (fill >= FILL_W'(MARKER_DEPTH));
  assign wr_slot  = read_ptr + fill[PTR_W-1:0];
  assign msize    = rd_place[PLACE_W-1:CNT_W];
  assign used_pop = (msize > used) ? '0 : used - msize;
  assign stat.rel_hit = (fill != '0) && (rd_frame <= bound);

  // Marker memory: one write port, one registered read port at the queue head.
  always_ff @(posedge clk) begin
    if (cmd.finish && !full) begin
      mark_place[wr_slot] <= {frame_bytes, tail};
      mark_frame[wr_slot] <= frame_number;
    end
    rd_place <= mark_place[read_ptr];
    rd_frame <= mark_frame[read_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RST;
      head        <= '0;
      tail        <= '0;
      used        <= '0;
      frame_bytes <= '0;
      read_ptr    <= '0;
      fill        <= '0;
      popped      <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.alloc || cmd.finish || cmd.nop || cmd.rel_done;
      if (cfg_we) begin
        buffer_size <= cfg_wdata;
      end
      if (cmd.alloc && grant) begin
        tail        <= tail_next;
        used        <= used_next;
        frame_bytes <= frame_next;
      end
      if (cmd.finish && !full) begin
        fill        <= fill + 1'b1;
        frame_bytes <= '0;
      end
      if (cmd.rel_start) begin
        popped <= '0;
      end
      if (cmd.rel_pop) begin
        used     <= used_pop;
        head     <= rd_place[CNT_W-1:0];
        read_ptr <= read_ptr + 1'b1;
        fill     <= fill - 1'b1;
        popped   <= popped + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rel_start) begin
      bound <= frame_number;
    end
    if (cmd.alloc) begin
      status         <= grant ? ST_OK : ST_NO_SPACE;
      offset         <= grant ? grant_off : '0;
      used_bytes     <= grant ? used_next : used;
      released_count <= '0;
    end else if (cmd.finish) begin
      status         <= full ? ST_FULL : ST_OK;
      offset         <= '0;
      used_bytes     <= used;
      released_count <= '0;
    end else if (cmd.nop) begin
      status         <= ST_OK;
      offset         <= '0;
      used_bytes     <= used;
      released_count <= '0;
    end else if (cmd.rel_done) begin
      status         <= ST_OK;
      offset         <= '0;
      used_bytes     <= used;
      released_count <= 5'(popped);
    end
  end

endmodule

`default_nettype wire

>>> rtl/frame_ring_allocator.sv
// Allocate, finish and undefined operations: done in the cycle after start; busy stays low.
// Release: each popped marker takes a pass through S_LOAD and S_CHECK; busy is high meanwhile.
// The pace of a release is set by the registered read of the marker memory.
// done is high for one cycle and the receiver cannot stall it; results hold until the next one.
// Synchronous reset empties the marker queue, zeroes the counters and sets buffer_size to 65536.
// ----------------------------------------------------------------------------
// frame_ring_allocator
// Ring buffer allocator with per-frame markers: allocates byte ranges from a
// ring and frees whole frames when they are released.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_ring_allocator
  import fra_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CNT_W-1:0]   cfg_wdata,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic [CNT_W-1:0]   alloc_size,
  input  wire logic [FRAME_W-1:0] frame_number,
  output logic                    done,
  output logic [1:0]              status,
  output logic [CNT_W-1:0]        offset,
  output logic [CNT_W-1:0]        used_bytes,
  output logic [4:0]              released_count
);

  fra_cmd_t  cmd;
  fra_stat_t stat;

  fra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fra_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .alloc_size     (alloc_size),
    .frame_number   (frame_number),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .status         (status),
    .offset         (offset),
    .used_bytes     (used_bytes),
    .released_count (released_count)
  );

endmodule

`default_nettype wire

>>> rtl/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker
// Port-level checks of the frame ring allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_checker
  import fra_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         func,
  input wire logic               done,
  input wire logic [1:0]         status,
  input wire logic [CNT_W-1:0]   offset,
  input wire logic [CNT_W-1:0]   used_bytes,
  input wire logic [4:0]         released_count
);

  // A non-release item answers in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func != FUNC_RELEASE)) |=> (done && !busy))
    else $error("non-release item did not answer in one cycle");

  // A release item always occupies the block for a while.
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_RELEASE)) |=> (busy && !done))
    else $error("release item did not raise busy");

  // Only a successful allocation reports a nonzero offset.
  a_offset_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (offset != '0)) |-> ((status == ST_OK) && (released_count == '0)))
    else $error("offset reported without a grant");

  // Used bytes never exceed the largest ring.
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (used_bytes <= RING_MAX))
    else $error("used bytes out of range");

  // Pops are only reported with an ok status.
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (done && (released_count != '0)) |-> (status == ST_OK))
    else $error("popped markers with an error status");

endmodule

bind frame_ring_allocator fra_checker u_fra_checker (.*);

`default_nettype wire
